/* rtl/core/rk4_driven_oscillator_step_defines.svh */
// Assertion macros shared by the oscillator step RTL.
`ifndef RK4_DRIVEN_OSCILLATOR_STEP_DEFINES_SVH
`define RK4_DRIVEN_OSCILLATOR_STEP_DEFINES_SVH

// Same-cycle implication, checked on every clock outside reset.
`define RK4_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every clock outside reset.
`define RK4_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/rk4osc_pkg.sv */
// Shared types, constants and helpers for the oscillator step block.
`timescale 1ns / 1ps

package rk4osc_pkg;

	localparam int SW     = 32;         // state width, signed Q8.24
	localparam int CW     = 16;         // cosine sample width, signed Q1.14
	localparam int WIDE_W = SW + 26;    // headroom for products and sums
	localparam int MB_W   = 25;         // multiplier b operand, signed
	localparam int ACC_W  = SW + 3;     // weighted sum of four k terms
	localparam int SPLIT  = 16;         // low slice of the sum for the final multiply
	localparam int IDX_W  = 3;
	localparam int CFG_W  = 32;
	localparam int CNT_W  = 5;

	localparam logic [23:0] SIXTH_Q24 = 24'd2796203;

	localparam logic [23:0] TIME_STEP_RST = 24'd167772;
	localparam logic [23:0] NAT_FREQ_RST  = 24'd1638400;
	localparam logic [23:0] DRIVE_AMP_RST = 24'd655360;
	localparam logic [31:0] START_POS_RST = 32'd16777216;
	localparam logic [31:0] START_VEL_RST = 32'd16777216;

	localparam logic [IDX_W-1:0] REG_TIME_STEP = 3'd0;
	localparam logic [IDX_W-1:0] REG_NAT_FREQ  = 3'd1;
	localparam logic [IDX_W-1:0] REG_DRIVE_AMP = 3'd2;
	localparam logic [IDX_W-1:0] REG_START_POS = 3'd3;
	localparam logic [IDX_W-1:0] REG_START_VEL = 3'd4;

	// Datapath operations: multiplier issue, write-back in the cycle after.
	localparam logic [3:0] OP_NOP    = 4'd0;
	localparam logic [3:0] OP_SPRING = 4'd1;
	localparam logic [3:0] OP_DRIVE  = 4'd2;
	localparam logic [3:0] OP_KX     = 4'd3;
	localparam logic [3:0] OP_KV     = 4'd4;
	localparam logic [3:0] OP_SPHI   = 4'd5;
	localparam logic [3:0] OP_SPLO   = 4'd6;
	localparam logic [3:0] OP_SVHI   = 4'd7;
	localparam logic [3:0] OP_SVLO   = 4'd8;
	localparam logic [3:0] OP_COMMIT = 4'd9;

	localparam logic [1:0] STAGE_LAST = 2'd3;

	// Sequencer layout: four stages of four operations each, then the final sum.
	localparam logic [CNT_W-1:0] CNT_FIN  = 5'd16;
	localparam logic [CNT_W-1:0] RUN_LAST = 5'd21;

	typedef struct packed {
		logic [23:0] time_step;
		logic [23:0] natural_freq_sq;
		logic [23:0] drive_amplitude;
		logic [31:0] start_position;
		logic [31:0] start_velocity;
	} cfg_t;

	typedef struct packed {
		logic       load;
		logic       restart;
		logic [3:0] op;
		logic [1:0] stage;
	} dp_cmd_t;

	typedef struct packed {
		logic [SW-1:0] val;
		logic          clip;
	} sat_t;

	// Clip a wide signed value to SW bits and flag the clip.
	function automatic sat_t sat_wide(input logic signed [WIDE_W-1:0] v);
		sat_t r;
		if (v[WIDE_W-1:SW-1] == '0 || v[WIDE_W-1:SW-1] == '1) begin
			r.val  = v[SW-1:0];
			r.clip = 1'b0;
		end else begin
			r.val  = {v[WIDE_W-1], {(SW-1){~v[WIDE_W-1]}}};
			r.clip = 1'b1;
		end
		return r;
	endfunction

endpackage

/* rtl/core/rk4osc_ctrl.sv */
// Sequencer for the oscillator step: issues one datapath operation per cycle.
`timescale 1ns / 1ps

module rk4osc_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       command,
	input  logic                       out_free,
	output logic                       in_ready,
	output logic                       out_load,
	output rk4osc_pkg::dp_cmd_t        cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]                   state_q;
	logic [rk4osc_pkg::CNT_W-1:0] cnt_q;
	logic                         accept;

	always_comb begin
		in_ready    = (state_q == ST_IDLE);
		accept      = in_valid && in_ready;
		out_load    = (state_q == ST_DONE) && out_free;
		cmd         = '0;
		cmd.load    = accept && !command;
		cmd.restart = accept && command;
		cmd.op      = rk4osc_pkg::OP_NOP;
		if (state_q == ST_RUN) begin
			if (cnt_q < rk4osc_pkg::CNT_FIN) begin
				cmd.stage = cnt_q[3:2];
				case (cnt_q[1:0])
					2'd0: cmd.op = rk4osc_pkg::OP_SPRING;
					2'd1: cmd.op = rk4osc_pkg::OP_DRIVE;
					2'd2: cmd.op = rk4osc_pkg::OP_KX;
					default: cmd.op = rk4osc_pkg::OP_KV;
				endcase
			end else begin
				case (cnt_q - rk4osc_pkg::CNT_FIN)
					5'd0: cmd.op = rk4osc_pkg::OP_SPHI;
					5'd1: cmd.op = rk4osc_pkg::OP_SPLO;
					5'd2: cmd.op = rk4osc_pkg::OP_SVHI;
					5'd3: cmd.op = rk4osc_pkg::OP_SVLO;
					5'd4: cmd.op = rk4osc_pkg::OP_COMMIT;
					default: cmd.op = rk4osc_pkg::OP_NOP;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= command ? ST_DONE : ST_RUN;
						cnt_q   <= '0;
					end
				end
				ST_RUN: begin
					if (cnt_q == rk4osc_pkg::RUN_LAST) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* rtl/core/rk4osc_dp.sv */
// Datapath for the oscillator step: shared multiplier, write-back and state.
`timescale 1ns / 1ps

module rk4osc_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rk4osc_pkg::dp_cmd_t               cmd,
	input  rk4osc_pkg::cfg_t                  cfg,
	input  logic signed [rk4osc_pkg::CW-1:0]  cos_start,
	input  logic signed [rk4osc_pkg::CW-1:0]  cos_mid,
	input  logic signed [rk4osc_pkg::CW-1:0]  cos_end,
	output logic signed [rk4osc_pkg::SW-1:0]  position,
	output logic signed [rk4osc_pkg::SW-1:0]  velocity,
	output logic                              clipped
);

	localparam int SW     = rk4osc_pkg::SW;
	localparam int CW     = rk4osc_pkg::CW;
	localparam int WIDE_W = rk4osc_pkg::WIDE_W;
	localparam int MB_W   = rk4osc_pkg::MB_W;
	localparam int ACC_W  = rk4osc_pkg::ACC_W;
	localparam int SPLIT  = rk4osc_pkg::SPLIT;

	// State and intermediate values
	logic signed [SW-1:0]     p0_q, v0_q;
	logic signed [SW-1:0]     pc_q, vc_q;
	logic signed [SW-1:0]     spring_q, acc_q;
	logic signed [SW-1:0]     fracp_q, fracv_q;
	logic signed [ACC_W-1:0]  sp_q, sv_q;
	logic signed [WIDE_W-1:0] hi_q;
	logic signed [CW-1:0]     cos0_q, cos1_q, cos2_q;
	logic                     clip_q;

	// Multiplier stage
	logic signed [SW-1:0]        a_op;
	logic signed [MB_W-1:0]      b_op;
	logic signed [CW-1:0]        cos_sel;
	logic signed [SW+MB_W-1:0]   mul_full;
	logic signed [WIDE_W-1:0]    prod_s1;
	logic [3:0]                  op_s1;
	logic [1:0]                  stage_s1;

	// Write-back logic
	rk4osc_pkg::sat_t         spring_w, drive_w, acc_w, k_w, nxt_w, frac_w, pos_w, vel_w;
	rk4osc_pkg::sat_t         start_pos_w, start_vel_w;
	logic signed [SW-1:0]     k_val, k_inc, nxt_base;
	logic signed [ACC_W-1:0]  k_acc, k_add;
	logic                     last_stage;

	always_comb begin
		case (cmd.stage)
			2'd0: cos_sel = cos0_q;
			rk4osc_pkg::STAGE_LAST: cos_sel = cos2_q;
			default: cos_sel = cos1_q;
		endcase
		a_op = '0;
		b_op = MB_W'(cfg.time_step);
		case (cmd.op)
			rk4osc_pkg::OP_SPRING: begin
				a_op = pc_q;
				b_op = MB_W'(cfg.natural_freq_sq);
			end
			rk4osc_pkg::OP_DRIVE: begin
				a_op = SW'(cos_sel);
				b_op = MB_W'(cfg.drive_amplitude);
			end
			rk4osc_pkg::OP_KX: a_op = vc_q;
			rk4osc_pkg::OP_KV: a_op = acc_q;
			rk4osc_pkg::OP_SPHI: begin
				a_op = SW'(sp_q >>> SPLIT);
				b_op = MB_W'(rk4osc_pkg::SIXTH_Q24);
			end
			rk4osc_pkg::OP_SPLO: begin
				a_op = SW'(sp_q[SPLIT-1:0]);
				b_op = MB_W'(rk4osc_pkg::SIXTH_Q24);
			end
			rk4osc_pkg::OP_SVHI: begin
				a_op = SW'(sv_q >>> SPLIT);
				b_op = MB_W'(rk4osc_pkg::SIXTH_Q24);
			end
			rk4osc_pkg::OP_SVLO: begin
				a_op = SW'(sv_q[SPLIT-1:0]);
				b_op = MB_W'(rk4osc_pkg::SIXTH_Q24);
			end
			default: a_op = '0;
		endcase
	end

	assign mul_full = a_op * b_op;

	always_comb begin
		last_stage = (stage_s1 == rk4osc_pkg::STAGE_LAST);
		spring_w   = rk4osc_pkg::sat_wide(prod_s1 >>> 16);
		drive_w    = rk4osc_pkg::sat_wide(prod_s1 >>> 22);
		acc_w      = rk4osc_pkg::sat_wide(WIDE_W'($signed(drive_w.val)) - WIDE_W'(spring_q));
		k_w        = rk4osc_pkg::sat_wide(prod_s1 >>> 24);
		k_val      = $signed(k_w.val);
		// half steps for the first two stages, full step for the third
		k_inc      = (stage_s1 < 2'd2) ? (k_val >>> 1) : k_val;
		nxt_base   = (op_s1 == rk4osc_pkg::OP_KX) ? p0_q : v0_q;
		nxt_w      = rk4osc_pkg::sat_wide(WIDE_W'(nxt_base) + WIDE_W'(k_inc));
		k_acc      = ACC_W'(k_val);
		k_add      = (stage_s1 == 2'd1 || stage_s1 == 2'd2) ? (k_acc <<< 1) : k_acc;
		frac_w     = rk4osc_pkg::sat_wide(((hi_q <<< SPLIT) + prod_s1) >>> 24);
		pos_w      = rk4osc_pkg::sat_wide(WIDE_W'(p0_q) + WIDE_W'(fracp_q));
		vel_w      = rk4osc_pkg::sat_wide(WIDE_W'(v0_q) + WIDE_W'(fracv_q));
		start_pos_w = rk4osc_pkg::sat_wide(WIDE_W'($signed(cfg.start_position)));
		start_vel_w = rk4osc_pkg::sat_wide(WIDE_W'($signed(cfg.start_velocity)));
	end

	// Control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1  <= rk4osc_pkg::OP_NOP;
			p0_q   <= $signed(SW'($signed(rk4osc_pkg::START_POS_RST)));
			v0_q   <= $signed(SW'($signed(rk4osc_pkg::START_VEL_RST)));
			clip_q <= 1'b0;
		end else begin
			op_s1 <= cmd.op;
			if (cmd.restart) begin
				p0_q   <= $signed(start_pos_w.val);
				v0_q   <= $signed(start_vel_w.val);
				clip_q <= start_pos_w.clip | start_vel_w.clip;
			end else if (cmd.load) begin
				clip_q <= 1'b0;
			end else begin
				case (op_s1)
					rk4osc_pkg::OP_SPRING: clip_q <= clip_q | spring_w.clip;
					rk4osc_pkg::OP_DRIVE:  clip_q <= clip_q | drive_w.clip | acc_w.clip;
					rk4osc_pkg::OP_KX,
					rk4osc_pkg::OP_KV:     clip_q <= clip_q | k_w.clip |
						(!last_stage && nxt_w.clip);
					rk4osc_pkg::OP_SPLO,
					rk4osc_pkg::OP_SVLO:   clip_q <= clip_q | frac_w.clip;
					rk4osc_pkg::OP_COMMIT: begin
						clip_q <= clip_q | pos_w.clip | vel_w.clip;
						p0_q   <= $signed(pos_w.val);
						v0_q   <= $signed(vel_w.val);
					end
					default: clip_q <= clip_q;
				endcase
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		prod_s1  <= WIDE_W'(mul_full);
		stage_s1 <= cmd.stage;
		if (cmd.load) begin
			cos0_q <= cos_start;
			cos1_q <= cos_mid;
			cos2_q <= cos_end;
			pc_q   <= p0_q;
			vc_q   <= v0_q;
			sp_q   <= '0;
			sv_q   <= '0;
		end else begin
			case (op_s1)
				rk4osc_pkg::OP_SPRING: spring_q <= $signed(spring_w.val);
				rk4osc_pkg::OP_DRIVE:  acc_q <= $signed(acc_w.val);
				rk4osc_pkg::OP_KX: begin
					sp_q <= sp_q + k_add;
					if (!last_stage) begin
						pc_q <= $signed(nxt_w.val);
					end
				end
				rk4osc_pkg::OP_KV: begin
					sv_q <= sv_q + k_add;
					if (!last_stage) begin
						vc_q <= $signed(nxt_w.val);
					end
				end
				rk4osc_pkg::OP_SPHI,
				rk4osc_pkg::OP_SVHI:   hi_q <= prod_s1;
				rk4osc_pkg::OP_SPLO:   fracp_q <= $signed(frac_w.val);
				rk4osc_pkg::OP_SVLO:   fracv_q <= $signed(frac_w.val);
				default: hi_q <= hi_q;
			endcase
		end
	end

	assign position = p0_q;
	assign velocity = v0_q;
	assign clipped  = clip_q;

endmodule

/* rtl/core/rk4_driven_oscillator_step.sv */
// Top level of the driven-oscillator RK4 step block: config, sequencer, datapath, output.
`timescale 1ns / 1ps

// Advances a driven harmonic oscillator (x'' = -w0^2*x + A*cos) by one classical
// fourth-order Runge-Kutta step per item; command 1 instead reloads the start
// position and velocity. Each item returns one result: the new state in signed
// Q8.24 and a flag that is set when any value in that item was clipped. The
// caller supplies the cosine samples at the start, midpoint and end of the step.
// Flow: a step item occupies the block from its accept through the sequencer
// run and the output state to the next accept; a restart item goes from its
// accept straight to the output state. The run length is set by the single
// shared 32x25 multiplier, which takes one operand pair per cycle for the 20
// products of a step and registers each product before write-back. A result
// waits in the output register, and the block accepts a new item while it
// waits; it stalls only when a second result is ready before the first is
// taken. Configuration writes are always accepted; make them only while no
// item is in flight, and they apply from the next item on.

`include "rk4_driven_oscillator_step_defines.svh"

module rk4_driven_oscillator_step (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// input items
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   command,
	input  logic signed [rk4osc_pkg::CW-1:0]       cos_start,
	input  logic signed [rk4osc_pkg::CW-1:0]       cos_mid,
	input  logic signed [rk4osc_pkg::CW-1:0]       cos_end,
	// result items
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [31:0]                     new_position,
	output logic signed [31:0]                     new_velocity,
	output logic                                   saturated,
	// configuration writes
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [rk4osc_pkg::IDX_W-1:0]           cfg_index,
	input  logic [rk4osc_pkg::CFG_W-1:0]           cfg_data
);

	rk4osc_pkg::cfg_t                    cfg_q;
	rk4osc_pkg::dp_cmd_t                 cmd;
	logic signed [rk4osc_pkg::SW-1:0]    position;
	logic signed [rk4osc_pkg::SW-1:0]    velocity;
	logic                                clipped;
	logic                                out_load;
	logic                                out_free;
	logic                                out_valid_q;

	// Config registers: always ready, unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.time_step       <= rk4osc_pkg::TIME_STEP_RST;
			cfg_q.natural_freq_sq <= rk4osc_pkg::NAT_FREQ_RST;
			cfg_q.drive_amplitude <= rk4osc_pkg::DRIVE_AMP_RST;
			cfg_q.start_position  <= rk4osc_pkg::START_POS_RST;
			cfg_q.start_velocity  <= rk4osc_pkg::START_VEL_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rk4osc_pkg::REG_TIME_STEP: cfg_q.time_step       <= cfg_data[23:0];
				rk4osc_pkg::REG_NAT_FREQ:  cfg_q.natural_freq_sq <= cfg_data[23:0];
				rk4osc_pkg::REG_DRIVE_AMP: cfg_q.drive_amplitude <= cfg_data[23:0];
				rk4osc_pkg::REG_START_POS: cfg_q.start_position  <= cfg_data[31:0];
				rk4osc_pkg::REG_START_VEL: cfg_q.start_velocity  <= cfg_data[31:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// The output slot can take a result if empty or being drained this cycle.
	assign out_free = !out_valid_q || out_ready;

	rk4osc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.out_free (out_free),
		.in_ready (in_ready),
		.out_load (out_load),
		.cmd      (cmd)
	);

	rk4osc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg       (cfg_q),
		.cos_start (cos_start),
		.cos_mid   (cos_mid),
		.cos_end   (cos_end),
		.position  (position),
		.velocity  (velocity),
		.clipped   (clipped)
	);

	// Output register: hold a result until taken, refill as soon as the slot is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			new_position <= 32'(position);
			new_velocity <= 32'(velocity);
			saturated    <= clipped;
		end
	end

	assign out_valid = out_valid_q;

	// A taken item keeps the input closed while it is worked on.
	`RK4_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input open after accept")
	// A result never overwrites one that is still waiting.
	`RK4_ASSERT_IMP(a_load_into_free, out_load, !out_valid || out_ready, "result overwritten")
	// A loaded result shows up on the output the next cycle.
	`RK4_ASSERT_NXT(a_load_shows, out_load, out_valid, "loaded result not shown")
	// The sequencer only finishes an item while the input is closed.
	`RK4_ASSERT_IMP(a_no_load_idle, in_ready, !out_load, "result loaded while idle")

endmodule

/* tb/oscillator_step_checker.sv */
// Result checker for the oscillator step block: predicts each result and compares it.
`timescale 1ns / 1ps

module oscillator_step_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic                               command,
	input  logic signed [rk4osc_pkg::CW-1:0]   cos_start,
	input  logic signed [rk4osc_pkg::CW-1:0]   cos_mid,
	input  logic signed [rk4osc_pkg::CW-1:0]   cos_end,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic signed [31:0]                 new_position,
	input  logic signed [31:0]                 new_velocity,
	input  logic                               saturated,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [rk4osc_pkg::IDX_W-1:0]       cfg_index,
	input  logic [rk4osc_pkg::CFG_W-1:0]       cfg_data,
	output int                                 mismatches,
	output int                                 owed
);

	typedef struct packed {
		logic [31:0] position;
		logic [31:0] velocity;
		logic        clipped;
	} osc_state_t;

	osc_state_t        expected_states[$];
	rk4osc_pkg::cfg_t  regs;
	longint            position;
	longint            velocity;
	bit                clip_seen;

	function automatic longint clamp(input longint v);
		longint hi;
		hi = (longint'(1) <<< (rk4osc_pkg::SW - 1)) - 1;
		if (v > hi) begin
			clip_seen = 1'b1;
			return hi;
		end
		if (v < -hi - 1) begin
			clip_seen = 1'b1;
			return -hi - 1;
		end
		return v;
	endfunction

	// floor(a * b / 2^s), clipped to the state range
	function automatic longint scale(input longint a, input logic [23:0] b, input int s);
		return clamp((a * longint'(b)) >>> s);
	endfunction

	function automatic longint accel(input longint p, input longint c);
		return clamp(scale(c, regs.drive_amplitude, 22) - scale(p, regs.natural_freq_sq, 16));
	endfunction

	function automatic osc_state_t advance(input logic restart,
			input logic signed [rk4osc_pkg::CW-1:0] c0, c1, c2);
		longint p, v, k1x, k1v, k2x, k2v, k3x, k3v, k4x, k4v;
		longint p1, v1, p2, v2, p3, v3, sp, sv;
		osc_state_t r;
		clip_seen = 1'b0;
		if (restart) begin
			position = clamp(longint'($signed(regs.start_position)));
			velocity = clamp(longint'($signed(regs.start_velocity)));
		end else begin
			p = position;
			v = velocity;
			// halves are floor halves, hence the arithmetic shift
			k1x = scale(v, regs.time_step, 24);
			k1v = scale(accel(p, longint'(c0)), regs.time_step, 24);
			p1  = clamp(p + (k1x >>> 1));
			v1  = clamp(v + (k1v >>> 1));
			k2x = scale(v1, regs.time_step, 24);
			k2v = scale(accel(p1, longint'(c1)), regs.time_step, 24);
			p2  = clamp(p + (k2x >>> 1));
			v2  = clamp(v + (k2v >>> 1));
			k3x = scale(v2, regs.time_step, 24);
			k3v = scale(accel(p2, longint'(c1)), regs.time_step, 24);
			p3  = clamp(p + k3x);
			v3  = clamp(v + k3v);
			k4x = scale(v3, regs.time_step, 24);
			k4v = scale(accel(p3, longint'(c2)), regs.time_step, 24);
			sp  = k1x + 2 * (k2x + k3x) + k4x;
			sv  = k1v + 2 * (k2v + k3v) + k4v;
			position = clamp(p + scale(sp, rk4osc_pkg::SIXTH_Q24, 24));
			velocity = clamp(v + scale(sv, rk4osc_pkg::SIXTH_Q24, 24));
		end
		r.position = position[31:0];
		r.velocity = velocity[31:0];
		r.clipped  = clip_seen;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		osc_state_t want;
		if (!arst_n) begin
			regs.time_step       = rk4osc_pkg::TIME_STEP_RST;
			regs.natural_freq_sq = rk4osc_pkg::NAT_FREQ_RST;
			regs.drive_amplitude = rk4osc_pkg::DRIVE_AMP_RST;
			regs.start_position  = rk4osc_pkg::START_POS_RST;
			regs.start_velocity  = rk4osc_pkg::START_VEL_RST;
			position = longint'($signed(rk4osc_pkg::START_POS_RST));
			velocity = longint'($signed(rk4osc_pkg::START_VEL_RST));
			expected_states.delete();
			mismatches <= 0;
			owed       <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					rk4osc_pkg::REG_TIME_STEP: regs.time_step       = cfg_data[23:0];
					rk4osc_pkg::REG_NAT_FREQ:  regs.natural_freq_sq = cfg_data[23:0];
					rk4osc_pkg::REG_DRIVE_AMP: regs.drive_amplitude = cfg_data[23:0];
					rk4osc_pkg::REG_START_POS: regs.start_position  = cfg_data[31:0];
					rk4osc_pkg::REG_START_VEL: regs.start_velocity  = cfg_data[31:0];
					default: ;
				endcase
			end
			// compare before pushing: a result never belongs to an item of the same cycle
			if (out_valid && out_ready) begin
				if (expected_states.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected result pos %h vel %h sat %b", $realtime,
							new_position, new_velocity, saturated);
					mismatches <= mismatches + 1;
				end else begin
					want = expected_states.pop_front();
					if (new_position !== want.position || new_velocity !== want.velocity ||
							saturated !== want.clipped) begin
						if (mismatches < 10)
							$display("%0t: expected pos %h vel %h sat %b, got pos %h vel %h sat %b",
								$realtime, want.position, want.velocity, want.clipped,
								new_position, new_velocity, saturated);
						mismatches <= mismatches + 1;
					end
				end
			end
			if (in_valid && in_ready)
				expected_states.push_back(advance(command, cos_start, cos_mid, cos_end));
			owed <= expected_states.size();
		end
	end

endmodule

/* tb/tb_rk4_driven_oscillator_step.sv */
// Testbench top for the oscillator step block: drives items and settings, gives the verdict.
`timescale 1ns / 1ps

module tb_rk4_driven_oscillator_step;

	localparam int CW    = rk4osc_pkg::CW;
	localparam int IDX_W = rk4osc_pkg::IDX_W;
	localparam int CFG_W = rk4osc_pkg::CFG_W;

	localparam logic CMD_STEP    = 1'b0;
	localparam logic CMD_RESTART = 1'b1;

	localparam int PHASES          = 9;
	localparam int PHASE_ITEMS     = 100;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int SETTLE_CYCLES   = 40;
	// The longest quiet stretch is the receiver hold-off.
	localparam int WATCHDOG_LIMIT  = 4000;

	// Cosine samples in Q1.14: plus and minus one, and the two ends of the field.
	localparam logic [CW-1:0] COS_PLUS_ONE  = CW'(16384);
	localparam logic [CW-1:0] COS_MINUS_ONE = CW'(-16384);
	localparam logic [CW-1:0] COS_MOST      = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] COS_LEAST     = {1'b1, {(CW-1){1'b0}}};

	typedef enum {SET_TAME, SET_TOP, SET_ZERO, SET_WILD} setting_kind_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic                 command;
	logic signed [CW-1:0] cos_start;
	logic signed [CW-1:0] cos_mid;
	logic signed [CW-1:0] cos_end;
	logic                 out_valid;
	logic                 out_ready;
	logic signed [31:0]   new_position;
	logic signed [31:0]   new_velocity;
	logic                 saturated;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [IDX_W-1:0]     cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	int mismatches;
	int owed;
	int send_idle_pct   = 0;
	int recv_idle_pct   = 0;
	int hold_offs_asked = 0;
	int hold_offs_done  = 0;
	int quiet_cycles    = 0;

	rk4_driven_oscillator_step DUT (.*);

	oscillator_step_checker result_check (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Receiver: drop ready at random; on request hold it low for a long stretch so
	// the block fills its output register and stalls its input.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_offs_done != hold_offs_asked) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_offs_done++;
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog: end the run when no channel has moved anything for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one item, after a random idle gap; return at the edge that accepts it,
	// with valid still high so a following item can go out back to back.
	task automatic offer(input logic cmd, input logic [CW-1:0] c0, c1, c2);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		command   <= cmd;
		cos_start <= c0;
		cos_mid   <= c1;
		cos_end   <= c2;
		do @(posedge clk); while (!in_ready);
	endtask

	// Drop valid and wait until every outstanding result has been taken.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (owed != 0);
	endtask

	// Hold the write until accepted; the caller drops valid after the last one.
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Let the block go idle, then write every register plus one unmapped index.
	// Junk in the upper byte of the 24-bit registers must be dropped by the block.
	task automatic load_settings(input logic [23:0] step_size, freq_sq, amplitude,
			input logic [31:0] pos0, vel0);
		logic [7:0] junk;
		junk = 8'($urandom);
		drain();
		write_reg(rk4osc_pkg::REG_TIME_STEP, {junk, step_size});
		write_reg(rk4osc_pkg::REG_NAT_FREQ, {~junk, freq_sq});
		write_reg(rk4osc_pkg::REG_DRIVE_AMP, {junk, amplitude});
		write_reg(IDX_W'(rk4osc_pkg::REG_START_VEL + 1 + $urandom_range(2)), $urandom);
		write_reg(rk4osc_pkg::REG_START_POS, pos0);
		write_reg(rk4osc_pkg::REG_START_VEL, vel0);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [CW-1:0] c [3];
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		command   = CMD_STEP;
		cos_start = '0;
		cos_mid   = '0;
		cos_end   = '0;
		cfg_valid = 1'b0;
		cfg_index = rk4osc_pkg::REG_TIME_STEP;
		cfg_data  = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: restart, then each cosine field at its extremes.
		offer(CMD_RESTART, COS_MOST, COS_LEAST, COS_PLUS_ONE);
		offer(CMD_STEP, '0, '0, '0);
		offer(CMD_STEP, COS_PLUS_ONE, COS_PLUS_ONE, COS_PLUS_ONE);
		offer(CMD_STEP, COS_MINUS_ONE, COS_MINUS_ONE, COS_MINUS_ONE);
		offer(CMD_STEP, COS_LEAST, COS_LEAST, COS_LEAST);
		offer(CMD_STEP, COS_MOST, COS_MOST, COS_MOST);
		offer(CMD_STEP, COS_PLUS_ONE, COS_MINUS_ONE, COS_LEAST);
		offer(CMD_STEP, '1, CW'(1), COS_MOST);

		// Everything at full scale: clipping on restart-free steps.
		load_settings('1, '1, '1, 32'h7FFF_FFFF, 32'h8000_0000);
		offer(CMD_RESTART, '0, '0, '0);
		offer(CMD_STEP, COS_PLUS_ONE, COS_PLUS_ONE, COS_PLUS_ONE);
		offer(CMD_STEP, COS_LEAST, COS_LEAST, COS_LEAST);
		offer(CMD_STEP, COS_MOST, COS_LEAST, COS_PLUS_ONE);

		// Everything zero: the state must not move.
		load_settings('0, '0, '0, 32'h8000_0000, 32'h7FFF_FFFF);
		offer(CMD_RESTART, '1, '1, '1);
		offer(CMD_STEP, COS_MOST, COS_MOST, COS_MOST);
		offer(CMD_STEP, COS_LEAST, COS_LEAST, COS_LEAST);

		// Nominal settings from a negative start.
		load_settings(rk4osc_pkg::TIME_STEP_RST, rk4osc_pkg::NAT_FREQ_RST,
			rk4osc_pkg::DRIVE_AMP_RST, 32'hFF00_0000, '0);
		offer(CMD_RESTART, '0, '0, '0);
		offer(CMD_STEP, COS_PLUS_ONE, COS_PLUS_ONE, COS_MINUS_ONE);
		offer(CMD_STEP, COS_MINUS_ONE, '0, COS_PLUS_ONE);

		for (int ph = 0; ph < PHASES; ph++) begin
			// Sender dense and receiver busy, then the reverse, then both flat out.
			send_idle_pct = (ph < 3) ? 8 : (ph < 6) ? 56 : 0;
			recv_idle_pct = (ph < 3) ? 56 : (ph < 6) ? 8 : 0;
			case (setting_kind_t'(ph % 4))
				SET_TAME: load_settings(24'($urandom_range(1, 1 << 20)),
					24'($urandom_range(1 << 22)), 24'($urandom), $urandom, $urandom);
				SET_TOP:  load_settings('1, '1, '1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
				SET_ZERO: load_settings('0, '0, '0, '0, 32'h8000_0000);
				default:  load_settings(24'($urandom), 24'($urandom), 24'($urandom),
					$urandom, $urandom);
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Hold off the receiver while items keep coming.
				if (n == 30 && (ph == 1 || ph == 7))
					hold_offs_asked++;
				// Pause the sender until every result is back.
				if (n == 50 && ph == 4)
					drain();
				// Mostly in-range cosines, some raw bit patterns.
				foreach (c[i])
					c[i] = ($urandom_range(3) == 0) ? CW'($urandom)
						: CW'($urandom_range(32768) - 16384);
				offer(($urandom_range(99) < 8) ? CMD_RESTART : CMD_STEP, c[0], c[1], c[2]);
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && owed == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
